// ===== hdl/rtas_pkg.sv =====
// Package for the ring traffic automaton step unit.
// Holds field widths, register codes, reset values, state and payload types,
// and the LFSR helper functions. No dependencies.
package rtas_pkg;

  localparam int DEFAULT_MAX_CARS  = 32;
  localparam int DEFAULT_CELL_BITS = 12;

  localparam int IDX_W   = 5;
  localparam int CELL_W  = 12;
  localparam int SPEED_W = 5;
  localparam int PROB_W  = 16;
  localparam int LFSR_W  = 16;
  localparam int ACT_W   = 6;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [LFSR_W-1:0] LFSR_TOGGLE = 16'hB400;

  localparam logic [CELL_W-1:0]  RESET_RING_LENGTH = 12'd1000;
  localparam logic [SPEED_W-1:0] RESET_MAX_SPEED   = 5'd20;
  localparam logic [PROB_W-1:0]  RESET_SLOW_PROB   = 16'd29491;
  localparam logic [LFSR_W-1:0]  RESET_RNG_SEED    = 16'd1;
  localparam logic [ACT_W-1:0]   RESET_ACTIVE_CARS = 6'd25;

  typedef enum logic [2:0] {
    REG_RING_LENGTH = 3'd0,
    REG_MAX_SPEED   = 3'd1,
    REG_SLOW_PROB   = 3'd2,
    REG_RNG_SEED    = 3'd3,
    REG_ACTIVE_CARS = 3'd4
  } reg_idx_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_MOD,
    S_CALC
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic [IDX_W-1:0]   car_index;
    logic [CELL_W-1:0]  cell_req;
    logic [SPEED_W-1:0] speed;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic [CELL_W-1:0]  out_cell;
    logic [SPEED_W-1:0] out_speed;
    logic               last;
  } rsp_t;

  // Galois LFSR, right shift.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TOGGLE;
    end
    return r;
  endfunction

  // A zero seed would lock the LFSR, so it loads one instead.
  function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
    return (s == '0) ? LFSR_W'(1) : s;
  endfunction

endpackage

// ===== hdl/rtas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come from parameters.
module rtas_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ring_traffic_automaton_step_unit.sv =====
// Ring traffic automaton step unit: Nagel-Schreckenberg update of up to
// MAX_CARS cars on a circular road, with an APB-style register port.
// Depends on rtas_pkg and rtas_ram.
//
// Request channel (req_valid / req_stall / req): a load request writes one
// car's cell and speed when it is taken and gives no response. A tick request
// walks the active cars in slot order and gives one response per car on
// rsp_valid / rsp_stall / rsp, with last set on the final car.
// A tick holds the request side until its final car has been updated, so the
// next request is taken after the tick; a car whose stored cell is not below
// the ring length also passes through the shared restoring modulo unit. The
// walk reads one car word per step from the car RAM.
// req_stall is high for the whole tick. Responses sit in an output register;
// while the receiver stalls, the walk holds before producing the next car.
// Reset loads the register defaults and seeds the LFSR; car storage holds no
// defined value until loaded. Writing rng_seed reloads the LFSR.
module ring_traffic_automaton_step_unit
  import rtas_pkg::*;
#(
  parameter int MAX_CARS  = DEFAULT_MAX_CARS,
  parameter int CELL_BITS = DEFAULT_CELL_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_CARS);
  localparam int NW = $clog2(MAX_CARS + 1);
  localparam int WW = NW + 1;
  localparam int LW = CELL_BITS + 1;
  localparam int GW = CELL_BITS + 2;
  localparam int MW = CELL_BITS + SPEED_W;
  localparam int CW = $clog2(CELL_BITS);
  localparam logic [16:0] LEN_CAP = 17'(2 ** CELL_BITS);
  localparam logic [6:0]  N_CAP   = 7'(MAX_CARS);

  // configuration registers
  logic [CELL_W-1:0]  ring_length;
  logic [SPEED_W-1:0] max_speed;
  logic [PROB_W-1:0]  slow_probability;
  logic [LFSR_W-1:0]  rng_seed;
  logic [ACT_W-1:0]   active_cars;

  // sequencer registers
  state_t              state, state_next;
  logic [LW-1:0]       len_eff, len_eff_next;
  logic [NW-1:0]       n_eff, n_eff_next;
  logic [AW-1:0]       idx, idx_next;
  logic                first, first_next;
  logic [CELL_BITS-1:0] cur_cell, cur_cell_next;
  logic [SPEED_W-1:0]  cur_spd, cur_spd_next;
  logic [CELL_BITS-1:0] ahead_cell, ahead_cell_next;
  logic [SPEED_W-1:0]  ahead_spd, ahead_spd_next;
  logic [CELL_BITS-1:0] cell0, cell0_next;
  logic [CELL_BITS-1:0] rem, rem_next;
  logic [CELL_BITS-1:0] src, src_next;
  logic [CW-1:0]       mod_cnt, mod_cnt_next;
  logic [SPEED_W-1:0]  mod_spd, mod_spd_next;
  logic [LFSR_W-1:0]   lfsr, lfsr_next;
  logic                rsp_valid_next;
  rsp_t                rsp_next;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  logic cfg_wr;
  reg_idx_t cfg_addr;

  logic [16:0]   ring_wide, len_sel;
  logic [6:0]    act_wide, n_sel;
  logic [LW-1:0] len_cfg;
  logic [NW-1:0] n_cfg;

  // per-car arithmetic
  logic [GW-1:0]        gap_raw, gap;
  logic [5:0]           v_acc;
  logic [SPEED_W-1:0]   v_cap, v_fin;
  logic [LFSR_W-1:0]    lfsr_new;
  logic                 slow;
  logic [LW-1:0]        pos_raw, pos;
  logic [WW-1:0]        idx_p1, idx_p2;
  logic                 is_last;
  logic                 calc_fire;

  // reduction
  logic [CELL_BITS-1:0] rd_cell;
  logic [SPEED_W-1:0]   rd_spd;
  logic [LW-1:0]        trial;
  logic                 red_done;
  logic [CELL_BITS-1:0] red_val;
  logic [SPEED_W-1:0]   red_spd;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_addr = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length      <= RESET_RING_LENGTH;
      max_speed        <= RESET_MAX_SPEED;
      slow_probability <= RESET_SLOW_PROB;
      rng_seed         <= RESET_RNG_SEED;
      active_cars      <= RESET_ACTIVE_CARS;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_RING_LENGTH: ring_length      <= pwdata[CELL_W-1:0];
        REG_MAX_SPEED:   max_speed        <= pwdata[SPEED_W-1:0];
        REG_SLOW_PROB:   slow_probability <= pwdata[PROB_W-1:0];
        REG_RNG_SEED:    rng_seed         <= pwdata[LFSR_W-1:0];
        REG_ACTIVE_CARS: active_cars      <= pwdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_addr)
      REG_RING_LENGTH: prdata = PDATA_W'(ring_length);
      REG_MAX_SPEED:   prdata = PDATA_W'(max_speed);
      REG_SLOW_PROB:   prdata = PDATA_W'(slow_probability);
      REG_RNG_SEED:    prdata = PDATA_W'(rng_seed);
      REG_ACTIVE_CARS: prdata = PDATA_W'(active_cars);
      default:         prdata = '0;
    endcase
  end

  // effective ring length and car count for a tick
  always_comb begin
    ring_wide = 17'(ring_length);
    if (ring_wide > LEN_CAP) begin
      len_sel = LEN_CAP;
    end else if (ring_wide < 17'd2) begin
      len_sel = 17'd2;
    end else begin
      len_sel = ring_wide;
    end
    len_cfg = LW'(len_sel);

    act_wide = 7'(active_cars);
    if (act_wide == 7'd0) begin
      n_sel = 7'd1;
    end else if (act_wide > N_CAP) begin
      n_sel = N_CAP;
    end else begin
      n_sel = act_wide;
    end
    n_cfg = NW'(n_sel);
  end

  // one car update: accelerate, cap at gap, random slowdown, move
  always_comb begin
    gap_raw = GW'(ahead_cell) + GW'(len_eff) - GW'(cur_cell) - GW'(1);
    gap = (gap_raw >= GW'(len_eff)) ? gap_raw - GW'(len_eff) : gap_raw;
    v_acc = 6'(cur_spd) + 6'd1;
    if (v_acc > 6'(max_speed)) begin
      v_acc = 6'(max_speed);
    end
    if (GW'(v_acc) > gap) begin
      v_cap = SPEED_W'(gap);
    end else begin
      v_cap = SPEED_W'(v_acc);
    end
    lfsr_new = lfsr_step(lfsr);
    slow = (17'(lfsr_new) - 17'd1) < 17'(slow_probability);
    v_fin = (slow && v_cap != '0) ? v_cap - SPEED_W'(1) : v_cap;
    pos_raw = LW'(cur_cell) + LW'(v_fin);
    pos = (pos_raw >= len_eff) ? pos_raw - len_eff : pos_raw;
    idx_p1 = WW'(idx) + WW'(1);
    idx_p2 = WW'(idx) + WW'(2);
    is_last = (idx_p1 == WW'(n_eff));
  end

  assign rd_cell   = ram_rdata[MW-1:SPEED_W];
  assign rd_spd    = ram_rdata[SPEED_W-1:0];
  assign trial     = {rem, src[CELL_BITS-1]} >= len_eff ?
                     {rem, src[CELL_BITS-1]} - len_eff : {rem, src[CELL_BITS-1]};
  assign calc_fire = (state == S_CALC) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      lfsr      <= seed_value(RESET_RNG_SEED);
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      lfsr      <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    len_eff    <= len_eff_next;
    n_eff      <= n_eff_next;
    idx        <= idx_next;
    first      <= first_next;
    cur_cell   <= cur_cell_next;
    cur_spd    <= cur_spd_next;
    ahead_cell <= ahead_cell_next;
    ahead_spd  <= ahead_spd_next;
    cell0      <= cell0_next;
    rem        <= rem_next;
    src        <= src_next;
    mod_cnt    <= mod_cnt_next;
    mod_spd    <= mod_spd_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    len_eff_next    = len_eff;
    n_eff_next      = n_eff;
    idx_next        = idx;
    first_next      = first;
    cur_cell_next   = cur_cell;
    cur_spd_next    = cur_spd;
    ahead_cell_next = ahead_cell;
    ahead_spd_next  = ahead_spd;
    cell0_next      = cell0;
    rem_next        = rem;
    src_next        = src;
    mod_cnt_next    = mod_cnt;
    mod_spd_next    = mod_spd;
    lfsr_next       = lfsr;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = {pos[CELL_BITS-1:0], v_fin};
    ram_raddr       = '0;
    red_done        = 1'b0;
    red_val         = rd_cell;
    red_spd         = rd_spd;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_kind_t'(req.req_type) == REQ_LOAD) begin
            if (7'(req.car_index) < N_CAP) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(req.car_index);
              ram_wdata = {CELL_BITS'(req.cell_req), req.speed};
            end
          end else begin
            len_eff_next = len_cfg;
            n_eff_next   = n_cfg;
            idx_next     = '0;
            first_next   = 1'b1;
            ram_raddr    = '0;
            state_next   = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (LW'(rd_cell) < len_eff) begin
          red_done = 1'b1;
        end else begin
          rem_next     = '0;
          src_next     = rd_cell;
          mod_cnt_next = CW'(CELL_BITS - 1);
          mod_spd_next = rd_spd;
          state_next   = S_MOD;
        end
      end
      S_MOD: begin
        // restoring remainder, one dividend bit a cycle
        rem_next     = trial[CELL_BITS-1:0];
        src_next     = src << 1;
        mod_cnt_next = mod_cnt - CW'(1);
        if (mod_cnt == '0) begin
          red_done = 1'b1;
          red_val  = trial[CELL_BITS-1:0];
          red_spd  = mod_spd;
        end
      end
      S_CALC: begin
        if (calc_fire) begin
          ram_we              = 1'b1;
          lfsr_next           = lfsr_new;
          rsp_valid_next      = 1'b1;
          rsp_next.out_index  = IDX_W'(idx);
          rsp_next.out_cell   = CELL_W'(pos[CELL_BITS-1:0]);
          rsp_next.out_speed  = v_fin;
          rsp_next.last       = is_last;
          if (is_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next      = AW'(idx_p1);
            cur_cell_next = ahead_cell;
            cur_spd_next  = ahead_spd;
            if (idx_p2 < WW'(n_eff)) begin
              ram_raddr  = AW'(idx_p2);
              state_next = S_REDUCE;
            end else begin
              // final car looks at car 0's old cell
              ahead_cell_next = cell0;
              state_next      = S_CALC;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (red_done) begin
      if (first) begin
        first_next    = 1'b0;
        cell0_next    = red_val;
        cur_cell_next = red_val;
        cur_spd_next  = red_spd;
        if (n_eff == NW'(1)) begin
          ahead_cell_next = red_val;
          state_next      = S_CALC;
        end else begin
          ram_raddr  = AW'(1);
          state_next = S_REDUCE;
        end
      end else begin
        ahead_cell_next = red_val;
        ahead_spd_next  = red_spd;
        state_next      = S_CALC;
      end
    end

    if (cfg_wr && cfg_addr == REG_RNG_SEED) begin
      lfsr_next = seed_value(pwdata[LFSR_W-1:0]);
    end
  end

  rtas_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_CARS)
  ) u_car_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // both cells used by an update are already reduced into the ring
  a_calc_in_ring: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> (LW'(cur_cell) < len_eff && LW'(ahead_cell) < len_eff))
    else $error("car cell not reduced below ring length");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    calc_fire && is_last |=> state == S_IDLE && rsp_valid && rsp.last)
    else $error("tick did not end after final car");

  a_calc_emits: assert property (@(posedge clk) disable iff (rst)
    calc_fire |=> rsp_valid && lfsr != '0)
    else $error("car update lost its response or LFSR locked");

  a_mod_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD && mod_cnt == '0 |=> state == S_CALC || state == S_REDUCE)
    else $error("modulo unit did not hand back");

endmodule
